// File: rtl/core/smooth_vertex_lambert_shading_defines.svh
// Assertion helpers used by the checker of this block.
`ifndef SMOOTH_VERTEX_LAMBERT_SHADING_DEFINES_SVH
`define SMOOTH_VERTEX_LAMBERT_SHADING_DEFINES_SVH

// Checked only while out of reset.
`define SVLS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define SVLS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/svls_pkg.sv
`default_nettype none
package svls_pkg;

    localparam logic [1:0] FUNC_LOAD_VTX = 2'd0;
    localparam logic [1:0] FUNC_LOAD_TRI = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE  = 2'd2;

    localparam logic [2:0] REG_LIGHT_X     = 3'd0;
    localparam logic [2:0] REG_LIGHT_Y     = 3'd1;
    localparam logic [2:0] REG_LIGHT_Z     = 3'd2;
    localparam logic [2:0] REG_KEEP_RED    = 3'd3;
    localparam logic [2:0] REG_VERTEX_CNT  = 3'd4;
    localparam logic [2:0] REG_FACE_CNT    = 3'd5;

    localparam logic signed [15:0] LIGHT_X_RESET = 16'sd0;
    localparam logic signed [15:0] LIGHT_Y_RESET = -16'sd7327;
    localparam logic signed [15:0] LIGHT_Z_RESET = -16'sd14654;
    localparam logic [6:0]         VERTEX_CNT_RESET = 7'd64;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    localparam int VEC_W = 36;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } unit_vec_t;

    typedef struct packed {
        logic start;
        vec_t v;
    } norm_req_t;

    typedef struct packed {
        logic      done;
        unit_vec_t n;
    } norm_rsp_t;

endpackage
`default_nettype wire

// File: rtl/core/svls_norm.sv
`default_nettype none
// Iterative normalizer: scale below 2^30, sum of squares, bitwise isqrt,
// then three restoring dividers giving trunc(m * 16384 / len).
module svls_norm (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire svls_pkg::norm_req_t   req,
    output svls_pkg::norm_rsp_t        rsp
);
    import svls_pkg::*;

    typedef enum logic [5:0] {
        N_IDLE  = 6'b000001,
        N_SHIFT = 6'b000010,
        N_SQ    = 6'b000100,
        N_ROOT  = 6'b001000,
        N_DIV   = 6'b010000,
        N_DONE  = 6'b100000
    } nstate_t;

    nstate_t           state_reg;
    logic [2:0]        sgn_reg;
    logic [VEC_W-1:0]  mag_reg [3];
    logic [4:0]        cnt_reg;
    logic [63:0]       acc_reg;
    logic [63:0]       root_reg;
    logic [31:0]       rem_reg [3];
    logic [14:0]       low_reg [3];
    logic [14:0]       quo_reg [3];

    logic [VEC_W-1:0]  mag_or;
    logic [29:0]       sq_op;
    logic [59:0]       sq;
    logic [63:0]       bit_v;
    logic [63:0]       trial;
    logic [31:0]       div_t [3];
    logic [2:0]        div_ge;
    logic [VEC_W-1:0]  in_mag [3];
    logic              len_zero;
    logic signed [15:0] nq [3];

    always_comb begin
        mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];
        unique case (cnt_reg[1:0])
            2'd0:    sq_op = mag_reg[0][29:0];
            2'd1:    sq_op = mag_reg[1][29:0];
            default: sq_op = mag_reg[2][29:0];
        endcase
        sq    = 60'(sq_op) * 60'(sq_op);
        bit_v = 64'd1 << {cnt_reg, 1'b0};
        trial = root_reg + bit_v;
        in_mag[0] = req.v.x[VEC_W-1] ? VEC_W'(-req.v.x) : VEC_W'(req.v.x);
        in_mag[1] = req.v.y[VEC_W-1] ? VEC_W'(-req.v.y) : VEC_W'(req.v.y);
        in_mag[2] = req.v.z[VEC_W-1] ? VEC_W'(-req.v.z) : VEC_W'(req.v.z);
        len_zero = (root_reg[31:0] == 32'd0);
        for (int k = 0; k < 3; k++) begin
            div_t[k]  = {rem_reg[k][30:0], low_reg[k][14]};
            div_ge[k] = (div_t[k] >= root_reg[31:0]);
            if (len_zero) begin
                nq[k] = 16'sd0;
            end else if (sgn_reg[k]) begin
                nq[k] = -$signed({1'b0, quo_reg[k]});
            end else begin
                nq[k] = $signed({1'b0, quo_reg[k]});
            end
        end
    end

    assign rsp.done = (state_reg == N_DONE);
    assign rsp.n.x  = nq[0];
    assign rsp.n.y  = nq[1];
    assign rsp.n.z  = nq[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
        end else begin
            unique case (state_reg)
                N_IDLE: begin
                    if (req.start) begin
                        sgn_reg   <= {req.v.z[VEC_W-1], req.v.y[VEC_W-1], req.v.x[VEC_W-1]};
                        for (int k = 0; k < 3; k++) mag_reg[k] <= in_mag[k];
                        acc_reg   <= 64'd0;
                        cnt_reg   <= 5'd0;
                        state_reg <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    if (|mag_or[VEC_W-1:30]) begin
                        for (int k = 0; k < 3; k++) mag_reg[k] <= mag_reg[k] >> 1;
                    end else begin
                        state_reg <= N_SQ;
                    end
                end
                N_SQ: begin
                    acc_reg <= acc_reg + 64'(sq);
                    if (cnt_reg == 5'd2) begin
                        cnt_reg   <= 5'd31;
                        root_reg  <= 64'd0;
                        state_reg <= N_ROOT;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                N_ROOT: begin
                    if (acc_reg >= trial) begin
                        acc_reg  <= acc_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_v;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    if (cnt_reg == 5'd0) begin
                        for (int k = 0; k < 3; k++) begin
                            rem_reg[k] <= 32'(mag_reg[k][29:1]);
                            low_reg[k] <= {mag_reg[k][0], 14'd0};
                            quo_reg[k] <= 15'd0;
                        end
                        cnt_reg   <= 5'd14;
                        state_reg <= N_DIV;
                    end else begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                N_DIV: begin
                    for (int k = 0; k < 3; k++) begin
                        rem_reg[k] <= div_ge[k] ? div_t[k] - root_reg[31:0] : div_t[k];
                        quo_reg[k] <= {quo_reg[k][13:0], div_ge[k]};
                        low_reg[k] <= {low_reg[k][13:0], 1'b0};
                    end
                    if (cnt_reg == 5'd0) begin
                        state_reg <= N_DONE;
                    end else begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                N_DONE: begin
                    state_reg <= N_IDLE;
                end
                default: begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/smooth_vertex_lambert_shading.sv
`default_nettype none
// Gouraud vertex shading with Lambert lighting. Load items (vertex or
// triangle) may follow back to back. A compute item holds s_ready low
// until the machine is back in idle after its vertex pass: first a
// clearing pass over all MAX_VERTICES normal accumulators, then a pass per
// face (a face with a corner out of range is skipped) and a pass per vertex
// that ends in a colour transfer and its output wait. Per-item time is set by the shared
// normalizer (32-step square root, 15-step division) and the single read
// port of the vertex and accumulator memories.
module smooth_vertex_lambert_shading #(
    parameter int MAX_VERTICES  = 64,
    parameter int MAX_TRIANGLES = 128
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_func,
    input  wire logic [6:0]         s_slot,
    input  wire logic signed [15:0] s_pos_x,
    input  wire logic signed [15:0] s_pos_y,
    input  wire logic signed [15:0] s_pos_z,
    input  wire logic [7:0]         s_red_in,
    input  wire logic [5:0]         s_corner_a,
    input  wire logic [5:0]         s_corner_b,
    input  wire logic [5:0]         s_corner_c,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [5:0]              m_vertex_id,
    output logic [7:0]              m_red,
    output logic [7:0]              m_green,
    output logic [7:0]              m_blue,
    output logic [7:0]              m_alpha,
    output logic                    m_last
);
    import svls_pkg::*;

    localparam int VAW  = $clog2(MAX_VERTICES);
    localparam int VCW  = 8;
    localparam int TAW  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int TCW  = $clog2(MAX_TRIANGLES + 1);
    localparam int FCW  = ((TCW > 8) ? TCW : 8) + 1;

    typedef enum logic [15:0] {
        ST_IDLE   = 16'b0000000000000001,
        ST_CLEAR  = 16'b0000000000000010,
        ST_FACE   = 16'b0000000000000100,
        ST_TRI    = 16'b0000000000001000,
        ST_PA     = 16'b0000000000010000,
        ST_PB     = 16'b0000000000100000,
        ST_PC     = 16'b0000000001000000,
        ST_CROSS  = 16'b0000000010000000,
        ST_FNORM  = 16'b0000000100000000,
        ST_ACC_RD = 16'b0000001000000000,
        ST_ACC_WR = 16'b0000010000000000,
        ST_VTX    = 16'b0000100000000000,
        ST_VRD    = 16'b0001000000000000,
        ST_VNORM  = 16'b0010000000000000,
        ST_DOT    = 16'b0100000000000000,
        ST_WAIT   = 16'b1000000000000000
    } state_t;

    // memories
    logic [55:0] vtx_mem [MAX_VERTICES];
    logic [17:0] tri_mem [MAX_TRIANGLES];
    logic [68:0] sum_mem [MAX_VERTICES];
    logic [55:0] vtx_rdata_reg;
    logic [17:0] tri_rdata_reg;
    logic [68:0] sum_rdata_reg;

    // configuration
    logic signed [15:0] light_x_reg, light_y_reg, light_z_reg;
    logic               keep_red_reg;
    logic [6:0]         vertex_cnt_reg;
    logic [7:0]         face_cnt_reg;

    state_t             state_reg;
    logic [VCW-1:0]     vcnt_reg, nv_reg;
    logic [FCW-1:0]     fcnt_reg, nf_reg;
    logic [2:0]         step_reg;
    logic [5:0]         ca_reg, cb_reg, cc_reg;
    logic [47:0]        pa_reg;
    logic signed [16:0] e1_reg [3];
    logic signed [16:0] e2_reg [3];
    logic signed [33:0] prod_reg;
    logic signed [35:0] cr_reg [3];
    logic signed [33:0] dot_reg;
    unit_vec_t          nrm_reg;
    logic [7:0]         red_reg;
    logic               start_reg;
    vec_t               vec_reg;
    logic               m_valid_reg;
    logic [5:0]         m_vid_reg;
    logic [7:0]         m_red_reg, m_int_reg;
    logic               m_last_reg;

    norm_req_t          nreq;
    norm_rsp_t          nrsp;

    logic               s_fire;
    logic [VAW-1:0]     vtx_raddr, sum_raddr;
    logic               sum_we;
    logic [VAW-1:0]     sum_waddr;
    logic [68:0]        sum_wdata;
    logic [VCW-1:0]     slot_v, ca_ext, cb_ext, cc_ext, corner_sel;
    logic [FCW-1:0]     slot_t;
    logic               slot_v_ok, slot_t_ok, corners_ok;
    logic signed [16:0] opa, opb;
    logic signed [33:0] mul_res;
    logic [41:0]        dot_scaled;
    logic [7:0]         inten;
    logic [2:0]         sacc;
    logic [VCW-1:0]     nv_sat;
    logic [FCW-1:0]     nf_sat;

    function automatic logic signed [16:0] sx17(input logic [15:0] v);
        return {v[15], v};
    endfunction

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    assign nreq.start = start_reg;
    assign nreq.v     = vec_reg;

    svls_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (nreq),
        .rsp     (nrsp)
    );

    always_comb begin
        slot_v     = VCW'(s_slot);
        slot_t     = FCW'(s_slot);
        slot_v_ok  = slot_v < VCW'(MAX_VERTICES);
        slot_t_ok  = slot_t < FCW'(MAX_TRIANGLES);
        ca_ext     = VCW'(tri_rdata_reg[17:12]);
        cb_ext     = VCW'(tri_rdata_reg[11:6]);
        cc_ext     = VCW'(tri_rdata_reg[5:0]);
        corners_ok = (ca_ext < VCW'(MAX_VERTICES)) && (cb_ext < VCW'(MAX_VERTICES))
                     && (cc_ext < VCW'(MAX_VERTICES));
        nv_sat = (VCW'(vertex_cnt_reg) > VCW'(MAX_VERTICES)) ? VCW'(MAX_VERTICES)
                                                            : VCW'(vertex_cnt_reg);
        nf_sat = (FCW'(face_cnt_reg) > FCW'(MAX_TRIANGLES)) ? FCW'(MAX_TRIANGLES)
                                                           : FCW'(face_cnt_reg);

        unique case (step_reg[1:0])
            2'd0:    corner_sel = VCW'(ca_reg);
            2'd1:    corner_sel = VCW'(cb_reg);
            default: corner_sel = VCW'(cc_reg);
        endcase

        vtx_raddr = vcnt_reg[VAW-1:0];
        sum_raddr = vcnt_reg[VAW-1:0];
        if (state_reg == ST_TRI) begin
            vtx_raddr = ca_ext[VAW-1:0];
        end else if (state_reg == ST_PA) begin
            vtx_raddr = VAW'(cb_reg);
        end else if (state_reg == ST_PB) begin
            vtx_raddr = VAW'(cc_reg);
        end
        if (state_reg == ST_ACC_RD) begin
            sum_raddr = corner_sel[VAW-1:0];
        end

        sum_we    = 1'b0;
        sum_waddr = vcnt_reg[VAW-1:0];
        sum_wdata = 69'd0;
        if (state_reg == ST_CLEAR) begin
            sum_we = 1'b1;
        end else if (state_reg == ST_ACC_WR) begin
            sum_we    = 1'b1;
            sum_waddr = corner_sel[VAW-1:0];
            sum_wdata = {sum_rdata_reg[68:46] + 23'(nrm_reg.x),
                         sum_rdata_reg[45:23] + 23'(nrm_reg.y),
                         sum_rdata_reg[22:0]  + 23'(nrm_reg.z)};
        end

        sacc = step_reg - 3'd1;
        if (state_reg == ST_DOT) begin
            unique case (step_reg[1:0])
                2'd0:    begin opa = 17'(nrm_reg.x); opb = 17'(light_x_reg); end
                2'd1:    begin opa = 17'(nrm_reg.y); opb = 17'(light_y_reg); end
                default: begin opa = 17'(nrm_reg.z); opb = 17'(light_z_reg); end
            endcase
        end else begin
            unique case (step_reg)
                3'd0:    begin opa = e1_reg[1]; opb = e2_reg[2]; end
                3'd1:    begin opa = e1_reg[2]; opb = e2_reg[1]; end
                3'd2:    begin opa = e1_reg[2]; opb = e2_reg[0]; end
                3'd3:    begin opa = e1_reg[0]; opb = e2_reg[2]; end
                3'd4:    begin opa = e1_reg[0]; opb = e2_reg[1]; end
                default: begin opa = e1_reg[1]; opb = e2_reg[0]; end
            endcase
        end
        mul_res = opa * opb;

        dot_scaled = {dot_reg[33:0], 8'd0} - 42'(dot_reg[33:0]);
        if (dot_reg <= 34'sd0) begin
            inten = 8'd0;
        end else if (|dot_scaled[41:36]) begin
            inten = 8'd255;
        end else begin
            inten = dot_scaled[35:28];
        end
    end

    // memory ports
    always_ff @(posedge aclk) begin
        if (s_fire && (s_func == FUNC_LOAD_VTX) && slot_v_ok) begin
            vtx_mem[slot_v[VAW-1:0]] <= {s_red_in, s_pos_x, s_pos_y, s_pos_z};
        end
        if (s_fire && (s_func == FUNC_LOAD_TRI) && slot_t_ok) begin
            tri_mem[slot_t[TAW-1:0]] <= {s_corner_a, s_corner_b, s_corner_c};
        end
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        vtx_rdata_reg <= vtx_mem[vtx_raddr];
        tri_rdata_reg <= tri_mem[fcnt_reg[TAW-1:0]];
        sum_rdata_reg <= sum_mem[sum_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_x_reg    <= LIGHT_X_RESET;
            light_y_reg    <= LIGHT_Y_RESET;
            light_z_reg    <= LIGHT_Z_RESET;
            keep_red_reg   <= 1'b0;
            vertex_cnt_reg <= VERTEX_CNT_RESET;
            face_cnt_reg   <= 8'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LIGHT_X:    light_x_reg    <= cfg_wdata;
                REG_LIGHT_Y:    light_y_reg    <= cfg_wdata;
                REG_LIGHT_Z:    light_z_reg    <= cfg_wdata;
                REG_KEEP_RED:   keep_red_reg   <= cfg_wdata[0];
                REG_VERTEX_CNT: vertex_cnt_reg <= cfg_wdata[6:0];
                REG_FACE_CNT:   face_cnt_reg   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire && (s_func == FUNC_COMPUTE)) begin
                        nv_reg    <= nv_sat;
                        nf_reg    <= nf_sat;
                        vcnt_reg  <= '0;
                        state_reg <= ST_CLEAR;
                    end
                end
                ST_CLEAR: begin
                    if (vcnt_reg == VCW'(MAX_VERTICES - 1)) begin
                        fcnt_reg  <= '0;
                        state_reg <= ST_FACE;
                    end else begin
                        vcnt_reg <= vcnt_reg + 1'b1;
                    end
                end
                ST_FACE: begin
                    if (fcnt_reg == nf_reg) begin
                        vcnt_reg  <= '0;
                        state_reg <= ST_VTX;
                    end else begin
                        state_reg <= ST_TRI;
                    end
                end
                ST_TRI: begin
                    ca_reg <= tri_rdata_reg[17:12];
                    cb_reg <= tri_rdata_reg[11:6];
                    cc_reg <= tri_rdata_reg[5:0];
                    if (corners_ok) begin
                        state_reg <= ST_PA;
                    end else begin
                        fcnt_reg  <= fcnt_reg + 1'b1;
                        state_reg <= ST_FACE;
                    end
                end
                ST_PA: begin
                    pa_reg    <= vtx_rdata_reg[47:0];
                    state_reg <= ST_PB;
                end
                ST_PB: begin
                    e1_reg[0] <= sx17(vtx_rdata_reg[47:32]) - sx17(pa_reg[47:32]);
                    e1_reg[1] <= sx17(vtx_rdata_reg[31:16]) - sx17(pa_reg[31:16]);
                    e1_reg[2] <= sx17(vtx_rdata_reg[15:0])  - sx17(pa_reg[15:0]);
                    state_reg <= ST_PC;
                end
                ST_PC: begin
                    e2_reg[0] <= sx17(vtx_rdata_reg[47:32]) - sx17(pa_reg[47:32]);
                    e2_reg[1] <= sx17(vtx_rdata_reg[31:16]) - sx17(pa_reg[31:16]);
                    e2_reg[2] <= sx17(vtx_rdata_reg[15:0])  - sx17(pa_reg[15:0]);
                    step_reg  <= 3'd0;
                    state_reg <= ST_CROSS;
                end
                ST_CROSS: begin
                    prod_reg <= mul_res;
                    if (step_reg != 3'd0 && step_reg != 3'd7) begin
                        if (!sacc[0]) begin
                            cr_reg[sacc[2:1]] <= 36'(prod_reg);
                        end else begin
                            cr_reg[sacc[2:1]] <= cr_reg[sacc[2:1]] - 36'(prod_reg);
                        end
                    end
                    if (step_reg == 3'd7) begin
                        vec_reg   <= {cr_reg[0], cr_reg[1], cr_reg[2]};
                        start_reg <= 1'b1;
                        state_reg <= ST_FNORM;
                    end else begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                ST_FNORM: begin
                    if (nrsp.done) begin
                        nrm_reg   <= nrsp.n;
                        step_reg  <= 3'd0;
                        state_reg <= ST_ACC_RD;
                    end
                end
                ST_ACC_RD: begin
                    state_reg <= ST_ACC_WR;
                end
                ST_ACC_WR: begin
                    if (step_reg == 3'd2) begin
                        fcnt_reg  <= fcnt_reg + 1'b1;
                        state_reg <= ST_FACE;
                    end else begin
                        step_reg  <= step_reg + 3'd1;
                        state_reg <= ST_ACC_RD;
                    end
                end
                ST_VTX: begin
                    if (vcnt_reg == nv_reg) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_VRD;
                    end
                end
                ST_VRD: begin
                    red_reg   <= vtx_rdata_reg[55:48];
                    vec_reg   <= {36'($signed(sum_rdata_reg[68:46])),
                                  36'($signed(sum_rdata_reg[45:23])),
                                  36'($signed(sum_rdata_reg[22:0]))};
                    start_reg <= 1'b1;
                    state_reg <= ST_VNORM;
                end
                ST_VNORM: begin
                    if (nrsp.done) begin
                        nrm_reg   <= nrsp.n;
                        step_reg  <= 3'd0;
                        dot_reg   <= 34'sd0;
                        state_reg <= ST_DOT;
                    end
                end
                ST_DOT: begin
                    prod_reg <= mul_res;
                    if (step_reg != 3'd0 && step_reg != 3'd4) begin
                        dot_reg <= dot_reg + prod_reg;
                    end
                    if (step_reg == 3'd4) begin
                        m_vid_reg   <= vcnt_reg[5:0];
                        m_red_reg   <= keep_red_reg ? red_reg : inten;
                        m_int_reg   <= inten;
                        m_last_reg  <= (vcnt_reg + 1'b1 == nv_reg);
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_WAIT;
                    end else begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                ST_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        vcnt_reg    <= vcnt_reg + 1'b1;
                        state_reg   <= ST_VTX;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_vertex_id = m_vid_reg;
    assign m_red       = m_red_reg;
    assign m_green     = m_int_reg;
    assign m_blue      = m_int_reg;
    assign m_alpha     = ALPHA_OPAQUE;
    assign m_last      = m_last_reg;

endmodule
`default_nettype wire

// File: rtl/core/svls_checker.sv
`default_nettype none
`include "smooth_vertex_lambert_shading_defines.svh"
module svls_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [5:0] m_vertex_id,
    input wire logic [7:0] m_red,
    input wire logic [7:0] m_green,
    input wire logic [7:0] m_blue,
    input wire logic [7:0] m_alpha,
    input wire logic       m_last
);
    import svls_pkg::*;

    `SVLS_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `SVLS_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_vertex_id) && $stable(m_red) && $stable(m_green) && $stable(m_last), "stalled result changed")
    `SVLS_ASSERT(a_busy_while_out, aclk, aresetn, m_valid |-> !s_ready, "input taken during emission")
    `SVLS_ASSERT(a_color_form, aclk, aresetn, m_valid |-> (m_green == m_blue) && (m_alpha == ALPHA_OPAQUE), "color channels inconsistent")
    `SVLS_ASSERT(a_id_steps, aclk, aresetn, m_valid && m_ready && !m_last |=> !s_ready, "run ended without last")

endmodule

bind smooth_vertex_lambert_shading svls_checker u_svls_checker (.*);
`default_nettype wire

// File: tb/tb_top.sv
module tb_top;
    import svls_pkg::*;

    localparam int WATCHDOG_LIMIT = 150000;
    localparam int HOLD_CYCLES    = 3000;

    typedef struct {
        logic [1:0]         func;
        logic [6:0]         slot;
        logic signed [15:0] px, py, pz;
        logic [7:0]         red;
        logic [5:0]         ca, cb, cc;
    } mesh_item_t;

    typedef struct {
        logic [5:0] vid;
        logic [7:0] red, green, blue, alpha;
        logic       last;
    } shade_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_func = '0;
    logic [6:0] s_slot = '0;
    logic signed [15:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic [7:0] s_red_in = '0;
    logic [5:0] s_corner_a = '0, s_corner_b = '0, s_corner_c = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [5:0] m_vertex_id;
    logic [7:0] m_red, m_green, m_blue, m_alpha;
    logic m_last;

    smooth_vertex_lambert_shading dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    mesh_item_t pend_q[$];
    shade_t     shade_q[$];
    mesh_item_t cur;
    int idle_pct = 0, stall_pct = 0, errors = 0, quiet = 0, hold_left = 0, vtx_hi = 0;
    bit hold_req = 0, s_xfer = 0;

    // shading model state
    longint lx = 0, ly = -7327, lz = -14654;
    bit keep_red = 0;
    int vcount = 64, fcount = 0;
    longint vpx[64], vpy[64], vpz[64];
    logic [7:0] vred[64];
    logic [5:0] tri_a[128], tri_b[128], tri_c[128];
    int sum_x[64], sum_y[64], sum_z[64];

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unit_part(longint c, longint unsigned m, longint unsigned len);
        longint q;
        q = (len == 0) ? 0 : longint'((m * 16384) / len);
        return c < 0 ? -q : q;
    endfunction

    task automatic unit_vec(input longint cx, cy, cz, output longint nx, ny, nz);
        longint unsigned m0, m1, m2, big, len;
        m0 = cx < 0 ? -cx : cx;
        m1 = cy < 0 ? -cy : cy;
        m2 = cz < 0 ? -cz : cz;
        big = m0 | m1 | m2;
        while (big >= (64'd1 << 30)) begin
            m0 >>= 1; m1 >>= 1; m2 >>= 1; big >>= 1;
        end
        len = isqrt(m0 * m0 + m1 * m1 + m2 * m2);
        nx = unit_part(cx, m0, len);
        ny = unit_part(cy, m1, len);
        nz = unit_part(cz, m2, len);
    endtask

    function automatic int wrap23(longint v);
        logic [22:0] t;
        t = v[22:0];
        return $signed({{9{t[22]}}, t});
    endfunction

    task automatic shade_item(mesh_item_t it);
        int nv, nf, a, b, c;
        longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz, dot;
        longint unsigned inten;
        shade_t s;
        if (it.func == FUNC_LOAD_VTX) begin
            if (it.slot < 64) begin
                vpx[it.slot] = it.px; vpy[it.slot] = it.py; vpz[it.slot] = it.pz;
                vred[it.slot] = it.red;
            end
        end else if (it.func == FUNC_LOAD_TRI) begin
            tri_a[it.slot] = it.ca; tri_b[it.slot] = it.cb; tri_c[it.slot] = it.cc;
        end else if (it.func == FUNC_COMPUTE) begin
            nv = vcount > 64 ? 64 : vcount;
            nf = fcount > 128 ? 128 : fcount;
            for (int v = 0; v < 64; v++) begin
                sum_x[v] = 0; sum_y[v] = 0; sum_z[v] = 0;
            end
            for (int f = 0; f < nf; f++) begin
                a = tri_a[f]; b = tri_b[f]; c = tri_c[f];
                e1x = vpx[b] - vpx[a]; e1y = vpy[b] - vpy[a]; e1z = vpz[b] - vpz[a];
                e2x = vpx[c] - vpx[a]; e2y = vpy[c] - vpy[a]; e2z = vpz[c] - vpz[a];
                unit_vec(e1y * e2z - e1z * e2y, e1z * e2x - e1x * e2z,
                         e1x * e2y - e1y * e2x, nx, ny, nz);
                sum_x[a] = wrap23(sum_x[a] + nx); sum_y[a] = wrap23(sum_y[a] + ny);
                sum_z[a] = wrap23(sum_z[a] + nz);
                sum_x[b] = wrap23(sum_x[b] + nx); sum_y[b] = wrap23(sum_y[b] + ny);
                sum_z[b] = wrap23(sum_z[b] + nz);
                sum_x[c] = wrap23(sum_x[c] + nx); sum_y[c] = wrap23(sum_y[c] + ny);
                sum_z[c] = wrap23(sum_z[c] + nz);
            end
            for (int v = 0; v < nv; v++) begin
                unit_vec(sum_x[v], sum_y[v], sum_z[v], nx, ny, nz);
                dot = nx * lx + ny * ly + nz * lz;
                inten = 0;
                if (dot > 0) begin
                    inten = (longint'(dot) * 255) >> 28;
                    if (inten > 255) inten = 255;
                end
                s.vid = v[5:0];
                s.red = keep_red ? vred[v] : inten[7:0];
                s.green = inten[7:0];
                s.blue = inten[7:0];
                s.alpha = ALPHA_OPAQUE;
                s.last = (v == nv - 1);
                shade_q = {shade_q, s};
            end
        end
    endtask

    // input side
    always @(negedge aclk) begin
        if (!s_valid || s_xfer) begin
            if (pend_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                cur = pend_q.pop_front();
                s_valid <= 1'b1;
                s_func <= cur.func; s_slot <= cur.slot;
                s_pos_x <= cur.px; s_pos_y <= cur.py; s_pos_z <= cur.pz;
                s_red_in <= cur.red;
                s_corner_a <= cur.ca; s_corner_b <= cur.cb; s_corner_c <= cur.cc;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side
    always @(negedge aclk) begin
        if (hold_req && m_valid) begin
            hold_req = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        shade_t e;
        s_xfer = aresetn && s_valid && s_ready;
        if (s_xfer) shade_item(cur);
        if (aresetn && m_valid && m_ready) begin
            if (shade_q.size() == 0) begin
                $error("unexpected colour transfer, vertex_id %0d", m_vertex_id);
                errors++;
            end else begin
                e = shade_q.pop_front();
                if (m_vertex_id !== e.vid) begin
                    $error("vertex_id exp %0d got %0d", e.vid, m_vertex_id); errors++;
                end
                if (m_red !== e.red) begin
                    $error("red exp %0d got %0d", e.red, m_red); errors++;
                end
                if (m_green !== e.green) begin
                    $error("green exp %0d got %0d", e.green, m_green); errors++;
                end
                if (m_blue !== e.blue) begin
                    $error("blue exp %0d got %0d", e.blue, m_blue); errors++;
                end
                if (m_alpha !== e.alpha) begin
                    $error("alpha exp %0d got %0d", e.alpha, m_alpha); errors++;
                end
                if (m_last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, m_last); errors++;
                end
            end
        end
        if (s_xfer || (m_valid && m_ready)) quiet = 0;
        else quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("FAIL smooth_vertex_lambert_shading");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_LIGHT_X:    lx = longint'($signed(val));
            REG_LIGHT_Y:    ly = longint'($signed(val));
            REG_LIGHT_Z:    lz = longint'($signed(val));
            REG_KEEP_RED:   keep_red = val[0];
            REG_VERTEX_CNT: vcount = val[6:0];
            REG_FACE_CNT:   fcount = val[7:0];
            default: ;
        endcase
    endtask

    task automatic push(logic [1:0] f, logic [6:0] sl, logic signed [15:0] x, y, z,
                        logic [7:0] r, logic [5:0] a, b, c);
        mesh_item_t it;
        it.func = f; it.slot = sl; it.px = x; it.py = y; it.pz = z;
        it.red = r; it.ca = a; it.cb = b; it.cc = c;
        if (f == FUNC_LOAD_VTX && sl == vtx_hi && sl < 64) vtx_hi++;
        pend_q = {pend_q, it};
    endtask

    function automatic logic signed [15:0] rnd_pos();
        int v;
        v = $signed($urandom) >>> (32 - $urandom_range(3, 16));
        return v[15:0];
    endfunction

    function automatic logic [5:0] rnd_corner();
        return $urandom_range(0, vtx_hi - 1);
    endfunction

    task automatic mesh(int nv, int nf);
        logic [5:0] a, b;
        for (int i = 0; i < nv; i++)
            push(FUNC_LOAD_VTX, i, rnd_pos(), rnd_pos(), rnd_pos(), $urandom, $urandom, 0, 0);
        for (int i = 0; i < nf; i++) begin
            a = rnd_corner();
            b = ($urandom_range(0, 7) == 0) ? a : rnd_corner();
            push(FUNC_LOAD_TRI, i, $urandom, $urandom, $urandom, $urandom, a, b, rnd_corner());
        end
        case ($urandom_range(0, 3))
            0: push(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
            1: push(FUNC_LOAD_VTX, $urandom_range(64, 127), $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom);
            default: ;
        endcase
        push(FUNC_COMPUTE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom);
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || s_valid || shade_q.size() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_idle(int mode);
        case (mode % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 59; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 59; end
            default: begin idle_pct = 19; stall_pct = 19; end
        endcase
    endtask

    task automatic cfg_all(int x, y, z, int kr, int vc, int fc);
        cfg_write(REG_LIGHT_X, x[15:0]);
        cfg_write(REG_LIGHT_Y, y[15:0]);
        cfg_write(REG_LIGHT_Z, z[15:0]);
        cfg_write(REG_KEEP_RED, kr[15:0]);
        cfg_write(REG_VERTEX_CNT, vc[15:0]);
        cfg_write(REG_FACE_CNT, fc[15:0]);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // extremes, degenerate face, lone vertex, ignored items
        cfg_write(REG_VERTEX_CNT, 16'd5);
        cfg_write(REG_FACE_CNT, 16'd3);
        push(FUNC_LOAD_VTX, 0, 16'sh7fff, 16'sh8000, 16'sh7fff, 8'd0, 0, 0, 0);
        push(FUNC_LOAD_VTX, 1, 16'sh8000, 16'sh7fff, 16'sh8000, 8'd255, 0, 0, 0);
        push(FUNC_LOAD_VTX, 2, 16'sh8000, 16'sh8000, 16'sh7fff, 8'd170, 0, 0, 0);
        push(FUNC_LOAD_VTX, 3, 16'sd256, 16'sd0, 16'sd0, 8'd85, 0, 0, 0);
        push(FUNC_LOAD_VTX, 4, 16'sd0, 16'sd0, 16'sd0, 8'd1, 0, 0, 0);
        push(FUNC_LOAD_TRI, 0, 0, 0, 0, 0, 6'd0, 6'd1, 6'd2);
        push(FUNC_LOAD_TRI, 1, 0, 0, 0, 0, 6'd0, 6'd0, 6'd3);
        push(FUNC_LOAD_TRI, 2, 0, 0, 0, 0, 6'd3, 6'd2, 6'd1);
        push(FUNC_LOAD_VTX, 7'd127, 16'sh7fff, 16'sh7fff, 16'sh7fff, 8'd9, 0, 0, 0);
        push(2'd3, 7'd127, -1, -1, -1, 8'hff, 6'h3f, 6'h3f, 6'h3f);
        push(FUNC_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();
        cfg_all(16384, 0, 0, 1, 5, 3);
        push(FUNC_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();
        cfg_all(-16384, -16384, 16384, 0, 1, 0);
        push(FUNC_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();
        cfg_all(0, 16384, -16384, 1, 0, 2);
        push(FUNC_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // saturated vertex count, receiver held off while the sender keeps offering
        set_idle(3);
        cfg_all(-16384, 0, -16384, 0, 100, 20);
        mesh(16, 20);
        push(FUNC_LOAD_VTX, 0, rnd_pos(), rnd_pos(), rnd_pos(), $urandom, 0, 0, 0);
        hold_req = 1;
        drain();

        for (int p = 0; p < 7; p++) begin
            set_idle(p);
            cfg_all($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                    $urandom_range(0, 32768) - 16384, $urandom_range(0, 1),
                    $urandom_range(1, 6), $urandom_range(0, 6));
            mesh(vcount, fcount);
            drain();
        end

        if (errors == 0) begin
            $display("PASS smooth_vertex_lambert_shading");
        end else begin
            $display("FAIL smooth_vertex_lambert_shading");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/svls_pkg.sv
rtl/core/svls_norm.sv
rtl/core/smooth_vertex_lambert_shading.sv
rtl/core/svls_checker.sv
tb/tb_top.sv
